/* rtl/pdsc_pkg.sv */
// ----------------------------------------------------------------------------
// pdsc_pkg
// Types and constants shared by the packet deframer with additive check.
// ----------------------------------------------------------------------------
package pdsc_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam logic [7:0] LEN_OVERHEAD = 8'd4;
    localparam int TDATA_W = 32;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LEN_ERR = 2'd1,
        ST_SUM_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic       last;
        logic [7:0] payload_byte;
        status_t    status;
        logic [7:0] packet_type;
        logic [7:0] payload_count;
    } res_t;

endpackage

/* rtl/packet_deframer_sum_check.sv */
// ----------------------------------------------------------------------------
// packet_deframer_sum_check
// Byte stream deframer: finds packets by start byte, passes payload words on
// and ends each packet with a status word.
//
// channel   dir  handshake            content
// s_*       in   s_tvalid/s_tready    tdata[7:0] rx_byte
// m_*       out  m_tvalid/m_tready    tdata status record, tlast end of packet
// cfg_*     in   cfg_valid/cfg_ready  cfg_data start_byte
//
// One byte per cycle while s_tready is high; the phase machine settles each
// byte combinationally and its result word is registered in the result register, or in the skid stage while m_* stalls.
// Reset is synchronous on aresetn low: hunting, start byte 0.
// s_tready drops only while both the result register and the skid stage are
// full; cfg_ready is always high.
// ----------------------------------------------------------------------------
module packet_deframer_sum_check #(
    parameter int MAX_PAYLOAD = pdsc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] payload_byte, [9:8] status, [17:10] packet_type,
    // [25:18] payload_count, [31:26] zero
    output logic [pdsc_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_data
);
    import pdsc_pkg::*;

    logic [7:0] start_byte_reg;
    logic       in_accept;
    logic       res_push;
    res_t       res;
    res_t       out_res;
    logic       room;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign in_accept = s_tvalid && room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= 8'd0;
        end else if (cfg_valid) begin
            start_byte_reg <= cfg_data;
        end
    end

    pdsc_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .rx_byte    (s_tdata),
        .start_byte (start_byte_reg),
        .res_push   (res_push),
        .res        (res)
    );

    pdsc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tlast = out_res.last;
    assign m_tdata = {6'd0, out_res.payload_count, out_res.packet_type,
                      out_res.status, out_res.payload_byte};

endmodule

/* rtl/pdsc_core.sv */
// ----------------------------------------------------------------------------
// pdsc_core
// Phase machine: hunts for the start byte, reads length and type, passes on
// payload words, rejects lengths over MAX_PAYLOAD and checks the 8-bit wrapping sum.
// ----------------------------------------------------------------------------
module pdsc_core #(
    parameter int MAX_PAYLOAD = pdsc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      start_byte,
    output logic            res_push,
    output pdsc_pkg::res_t  res
);
    import pdsc_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] len_count;

    assign len_count = (rx_byte < LEN_OVERHEAD) ? 8'd0 : rx_byte - LEN_OVERHEAD;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        type_next  = type_reg;
        count_next = count_reg;
        res_push   = 1'b0;
        res        = '0;
        if (in_accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == start_byte) begin
                        sum_next   = rx_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (len_count > 8'(MAX_PAYLOAD)) begin
                        phase_next = PH_HUNT;
                        res_push   = 1'b1;
                        res.last   = 1'b1;
                        res.status = ST_LEN_ERR;
                    end else begin
                        sum_next   = sum_reg + rx_byte;
                        count_next = len_count;
                        left_next  = len_count;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    type_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = (left_reg != 8'd0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA: begin
                    sum_next         = sum_reg + rx_byte;
                    left_next        = left_reg - 8'd1;
                    if (left_reg == 8'd1) begin
                        phase_next = PH_CHECK;
                    end
                    res_push         = 1'b1;
                    res.payload_byte = rx_byte;
                end
                PH_CHECK: begin
                    phase_next        = PH_HUNT;
                    res_push          = 1'b1;
                    res.last          = 1'b1;
                    res.status        = (rx_byte == sum_reg) ? ST_OK : ST_SUM_ERR;
                    res.packet_type   = type_reg;
                    res.payload_count = count_reg;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            left_reg  <= 8'd0;
            type_reg  <= 8'd0;
            count_reg <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            left_reg  <= left_next;
            type_reg  <= type_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/pdsc_skid.sv */
// ----------------------------------------------------------------------------
// pdsc_skid
// Result register with a skid stage, so the input side keeps moving while
// a finished word waits on the output.
// ----------------------------------------------------------------------------
module pdsc_skid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pdsc_pkg::res_t  push_data,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output pdsc_pkg::res_t  out_data
);
    import pdsc_pkg::*;

    logic out_valid_reg;
    res_t out_data_reg;
    logic skd_valid_reg;
    res_t skd_data_reg;

    assign room      = !skd_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skd_valid_reg <= 1'b0;
        end else begin
            if (out_ready || !out_valid_reg) begin
                if (skd_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    skd_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= push;
                end
            end else if (push) begin
                skd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skd_valid_reg ? skd_data_reg : push_data;
        end else if (push) begin
            skd_data_reg <= push_data;
        end
    end

endmodule
